[design/ist_pkg.sv]
// shared types and constants for the integer set table
// no dependencies

package ist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int ECNT_W   = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [ECNT_W-1:0] element_count;
    logic              status;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic req_clear;
    logic out_free;
  } stat_t;

endpackage

[design/ist_ctrl.sv]
// request sequencer for the integer set table
// depends on ist_pkg

module ist_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ist_pkg::stat_t stat,
  output ist_pkg::cmd_t  cmd
);

  ist_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ist_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ist_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = stat.req_clear ? ist_pkg::ST_UPDATE : ist_pkg::ST_SCAN;
        end
      end
      ist_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ist_pkg::ST_DRAIN;
        end
      end
      ist_pkg::ST_DRAIN: begin
        state_next = ist_pkg::ST_UPDATE;
      end
      ist_pkg::ST_UPDATE: begin
        if (stat.out_free) begin
          state_next = ist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ist_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = (state == ist_pkg::ST_IDLE);
    cmd.start   = (state == ist_pkg::ST_IDLE) && req_valid;
    cmd.scan_en = (state == ist_pkg::ST_SCAN);
    cmd.update  = (state == ist_pkg::ST_UPDATE) && stat.out_free;
  end

endmodule

[design/ist_datapath.sv]
// table storage, scan compare and result register for the integer set table
// depends on ist_pkg

module ist_datapath (
  input  logic           clk,
  input  logic           rst,
  input  ist_pkg::req_t  req,
  input  ist_pkg::cmd_t  cmd,
  output ist_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ist_pkg::rsp_t  rsp
);

  logic [ist_pkg::VAL_W-1:0]    mem [ist_pkg::CAPACITY];
  logic [ist_pkg::VAL_W-1:0]    rd_data;
  logic [ist_pkg::CAPACITY-1:0] valid;
  logic [ist_pkg::CNT_W-1:0]    held_count;
  ist_pkg::req_t                req_q;
  logic [ist_pkg::IDX_W-1:0]    scan_idx;
  logic [ist_pkg::IDX_W-1:0]    cmp_idx;
  logic                         cmp_en;
  logic                         hit;
  logic [ist_pkg::IDX_W-1:0]    hit_idx;
  logic                         free_found;
  logic [ist_pkg::IDX_W-1:0]    free_idx;
  logic                         do_insert;
  logic                         do_delete;
  logic                         is_clear;

  assign is_clear  = (req_q.kind == ist_pkg::KIND_CLEAR);
  assign do_insert = cmd.update && (req_q.kind == ist_pkg::KIND_INSERT) && !hit && free_found;
  assign do_delete = cmd.update && (req_q.kind == ist_pkg::KIND_DELETE) && hit;

  assign stat.scan_last = (scan_idx == ist_pkg::IDX_W'(ist_pkg::CAPACITY - 1));
  assign stat.req_clear = (req.kind == ist_pkg::KIND_CLEAR);
  assign stat.out_free  = !rsp_valid || rsp_ready;

  // value memory
  always_ff @(posedge clk) begin
    if (do_insert) begin
      mem[free_idx] <= req_q.value;
    end
    rd_data <= mem[scan_idx];
  end

  // request latch and scan pipeline
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q <= req;
    end
    cmp_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      cmp_en     <= 1'b0;
      hit        <= 1'b0;
      hit_idx    <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else begin
      cmp_en <= cmd.scan_en;
      if (cmd.start) begin
        scan_idx   <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmp_en) begin
        if (!hit && valid[cmp_idx] && (rd_data == req_q.value)) begin
          hit     <= 1'b1;
          hit_idx <= cmp_idx;
        end
        if (!free_found && !valid[cmp_idx]) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

  // valid bits and element count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      held_count <= '0;
    end else if (cmd.update) begin
      priority if (is_clear) begin
        valid      <= '0;
        held_count <= '0;
      end else if (do_insert) begin
        valid[free_idx] <= 1'b1;
        held_count      <= held_count + 1'b1;
      end else if (do_delete) begin
        valid[hit_idx] <= 1'b0;
        held_count     <= held_count - 1'b1;
      end else begin
        held_count <= held_count;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.update) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp.found  <= hit && !is_clear;
      rsp.status <= (req_q.kind == ist_pkg::KIND_INSERT) && !hit && !free_found;
      priority if (is_clear) begin
        rsp.element_count <= '0;
      end else if (do_insert) begin
        rsp.element_count <= ist_pkg::ECNT_W'(held_count + 1'b1);
      end else if (do_delete) begin
        rsp.element_count <= ist_pkg::ECNT_W'(held_count - 1'b1);
      end else begin
        rsp.element_count <= ist_pkg::ECNT_W'(held_count);
      end
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(held_count) == 32'($countones(valid)))
    else $error("element count differs from number of valid entries");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> valid[$past(free_idx)])
    else $error("insert did not mark its slot valid");

  a_delete_clears_valid: assert property (@(posedge clk) disable iff (rst)
    do_delete |=> !valid[$past(hit_idx)])
    else $error("delete left its slot valid");

  a_no_scan_while_result_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !cmd.scan_en && !cmp_en)
    else $error("table update overlaps a scan");

endmodule

[design/integer_set_table_core.sv]
// integer set table: a request is accepted only while idle; it then scans the value
// memory (one entry read per cycle), drains the compare and updates, waiting in update
// while the previous result is held, and registers its result word there. A clear
// skips the scan. Reset clears all valid bits and the count at once; the value
// memory is not cleared. Depends on ist_pkg, ist_ctrl and ist_datapath.

module integer_set_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ist_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ist_pkg::rsp_t rsp
);

  ist_pkg::cmd_t  cmd;
  ist_pkg::stat_t stat;

  ist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ist_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
